// ----- hdl/redmean_closest_unused_color_macros.svh -----
// Assertion macros for the redmean closest unused color block.
`ifndef REDMEAN_CLOSEST_UNUSED_COLOR_MACROS_SVH
`define REDMEAN_CLOSEST_UNUSED_COLOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCUC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcuc assertion failed");

// Next-cycle implication, checked outside reset.
`define RCUC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcuc assertion failed");

`endif

// ----- hdl/rcuc_pkg.sv -----
// Shared types and codes for the redmean closest unused color block.
`timescale 1ns / 1ps
package rcuc_pkg;

   localparam int POOL_SIZE_DEF = 4096;
   localparam int INDEX_W       = 12;
   localparam int SCORE_W       = 20;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [2:0] STAT_LOADED = 3'd0;
   localparam logic [2:0] STAT_MATCH  = 3'd1;
   localparam logic [2:0] STAT_EMPTY  = 3'd2;
   localparam logic [2:0] STAT_FULL   = 3'd3;
   localparam logic [2:0] STAT_CLEAR  = 3'd4;

   // One pool entry moving down the scoring chain.
   typedef struct packed {
      logic       vld;
      logic       used;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } cand_type;

endpackage

// ----- hdl/rcuc_score.sv -----
// Pipelined redmean scoring chain: four register stages per candidate.
`timescale 1ns / 1ps
module rcuc_score #(
   parameter int IW = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              want_red,
   input  logic [7:0]              want_green,
   input  logic [7:0]              want_blue,
   input  rcuc_pkg::cand_type      cand_i,
   input  logic [IW-1:0]           idx_i,
   output rcuc_pkg::cand_type      cand_o,
   output logic [IW-1:0]           idx_o,
   output logic [rcuc_pkg::SCORE_W-1:0] score_o,
   output logic                    busy
);
   import rcuc_pkg::*;

   cand_type      cand_ff [4];
   cand_type      cand_in [4];
   logic [IW-1:0] idx_ff  [4];

   // stage A
   logic [7:0]  mean_ff, mean_in;
   logic [7:0]  dr_ff, dg_ff, db_ff, dr_in, dg_in, db_in;
   logic [8:0]  rsum;
   // stage B
   logic [9:0]  wr_ff, wb_ff, wr_in, wb_in;
   logic [15:0] sr_ff, sg_ff, sb_ff, sr_in, sg_in, sb_in;
   // stage C
   logic [25:0] pr, pb;
   logic [17:0] tr_ff, tg_ff, tb_ff, tr_in, tg_in, tb_in;
   // stage D
   logic [SCORE_W-1:0] sum_ff, sum_in;

   always_comb begin
      rsum  = {1'b0, want_red} + {1'b0, cand_i.red};
      mean_in = rsum[8:1];
      dr_in = (want_red   > cand_i.red)   ? want_red   - cand_i.red
                                          : cand_i.red   - want_red;
      dg_in = (want_green > cand_i.green) ? want_green - cand_i.green
                                          : cand_i.green - want_green;
      db_in = (want_blue  > cand_i.blue)  ? want_blue  - cand_i.blue
                                          : cand_i.blue  - want_blue;
      wr_in = 10'd512 + {2'b00, mean_ff};
      wb_in = 10'd767 - {2'b00, mean_ff};
      sr_in = dr_ff * dr_ff;
      sg_in = dg_ff * dg_ff;
      sb_in = db_ff * db_ff;
      pr    = 26'(wr_ff) * 26'(sr_ff);
      pb    = 26'(wb_ff) * 26'(sb_ff);
      tr_in = pr[25:8];
      tb_in = pb[25:8];
      tg_in = {sg_ff, 2'b00};
      sum_in = SCORE_W'(tr_ff) + SCORE_W'(tg_ff) + SCORE_W'(tb_ff);
      cand_in[0] = cand_i;
      for (int k = 1; k < 4; k++) begin
         cand_in[k] = cand_ff[k-1];
      end
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            cand_in[k].vld = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         cand_ff[k] <= cand_in[k];
      end
      idx_ff[0] <= idx_i;
      for (int k = 1; k < 4; k++) begin
         idx_ff[k] <= idx_ff[k-1];
      end
      mean_ff <= mean_in;
      dr_ff   <= dr_in;
      dg_ff   <= dg_in;
      db_ff   <= db_in;
      wr_ff   <= wr_in;
      wb_ff   <= wb_in;
      sr_ff   <= sr_in;
      sg_ff   <= sg_in;
      sb_ff   <= sb_in;
      tr_ff   <= tr_in;
      tg_ff   <= tg_in;
      tb_ff   <= tb_in;
      sum_ff  <= sum_in;
   end

   assign cand_o  = cand_ff[3];
   assign idx_o   = idx_ff[3];
   assign score_o = sum_ff;
   assign busy    = cand_ff[0].vld | cand_ff[1].vld | cand_ff[2].vld | cand_ff[3].vld;

endmodule

// ----- hdl/rcuc_best.sv -----
// Running minimum over scored candidates; first lowest score wins.
`timescale 1ns / 1ps
module rcuc_best #(
   parameter int IW = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  rcuc_pkg::cand_type      cand_i,
   input  logic [IW-1:0]           idx_i,
   input  logic [rcuc_pkg::SCORE_W-1:0] score_i,
   output logic                    found,
   output rcuc_pkg::cand_type      best_cand,
   output logic [IW-1:0]           best_idx,
   output logic [rcuc_pkg::SCORE_W-1:0] best_score
);
   import rcuc_pkg::*;

   logic               found_ff, found_in;
   logic               take;
   cand_type           cand_ff;
   logic [IW-1:0]      idx_ff;
   logic [SCORE_W-1:0] score_ff;

   always_comb begin
      take     = cand_i.vld && !cand_i.used && (!found_ff || (score_i < score_ff));
      found_in = found_ff;
      if (start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      if (take && !start) begin
         cand_ff  <= cand_i;
         idx_ff   <= idx_i;
         score_ff <= score_i;
      end
   end

   assign found      = found_ff;
   assign best_cand  = cand_ff;
   assign best_idx   = idx_ff;
   assign best_score = score_ff;

endmodule

// ----- hdl/redmean_closest_unused_color.sv -----
// Top level: color pool memory, scan sequencer, scoring chain and result register.
// Load, clear: result registered at the accepting edge.
// Query: the scan reads one pool entry per cycle from the pool memory port, then the
// 5-stage read/score chain drains into the minimum.
// One item in flight at a time; a new item is taken while a result waits if it drains.
// Reset (synchronous, active high) empties the pool; pool memory is not cleared.
`timescale 1ns / 1ps
module redmean_closest_unused_color #(
   parameter int POOL_SIZE = rcuc_pkg::POOL_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_match_red,
   output logic [7:0]  rsp_match_green,
   output logic [7:0]  rsp_match_blue,
   output logic [11:0] rsp_match_index,
   output logic [19:0] rsp_match_score
);
   import rcuc_pkg::*;

   localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CW = $clog2(POOL_SIZE + 1);
   localparam logic [CW-1:0] POOL_FULL = CW'(POOL_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // pool storage, written by loads and by the match update
   logic [23:0] pool_mem [POOL_SIZE];
   logic        used_mem [POOL_SIZE];

   logic [CW-1:0] entry_count_ff, entry_count_in;
   logic [CW-1:0] unused_count_ff, unused_count_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic [7:0]    want_r_ff, want_g_ff, want_b_ff;

   // memory read stage feeding the chain
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff;
   logic [23:0]   rd_color_ff;
   logic          rd_used_ff;

   logic     accept;
   logic     issue;
   logic     start;
   cand_type chain_in, chain_out, best_cand;
   logic [AW-1:0]      chain_idx, best_idx;
   logic [SCORE_W-1:0] chain_score, best_score;
   logic               chain_busy, found;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            status_ff, status_in;
   logic [23:0]           color_ff, color_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [SCORE_W-1:0]    score_ff, score_in;
   logic [AW+INDEX_W-1:0] slot_ext;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          used_wdata;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_action == ACT_QUERY);
   assign issue     = (state_ff == ST_SCAN) && (addr_ff != entry_count_ff);
   assign slot_ext  = {{INDEX_W{1'b0}}, best_idx};

   always_comb begin
      state_in        = state_ff;
      entry_count_in  = entry_count_ff;
      unused_count_in = unused_count_ff;
      addr_in         = addr_ff;
      rd_vld_in       = issue;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      status_in       = status_ff;
      color_in        = color_ff;
      index_in        = index_ff;
      score_in        = score_ff;
      mem_we          = 1'b0;
      mem_waddr       = entry_count_ff[AW-1:0];
      used_wdata      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               color_in = 24'd0;
               index_in = '0;
               score_in = '0;
               case (req_action)
                  ACT_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (entry_count_ff == POOL_FULL) begin
                        status_in = STAT_FULL;
                     end else begin
                        status_in       = STAT_LOADED;
                        mem_we          = 1'b1;
                        entry_count_in  = entry_count_ff + 1'b1;
                        unused_count_in = unused_count_ff + 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     if (unused_count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STAT_EMPTY;
                     end else begin
                        addr_in  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_valid_in    = 1'b1;
                     status_in       = STAT_CLEAR;
                     entry_count_in  = '0;
                     unused_count_in = '0;
                  end
                  default: begin
                     // meaningless action: consumed silently
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !chain_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // mark the winner used and publish it
            mem_we          = 1'b1;
            mem_waddr       = best_idx;
            used_wdata      = 1'b1;
            unused_count_in = unused_count_ff - 1'b1;
            rsp_valid_in    = 1'b1;
            status_in       = STAT_MATCH;
            color_in        = {best_cand.red, best_cand.green, best_cand.blue};
            index_in        = slot_ext[INDEX_W-1:0];
            score_in        = best_score;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         entry_count_ff  <= '0;
         unused_count_ff <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         entry_count_ff  <= entry_count_in;
         unused_count_ff <= unused_count_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      addr_ff   <= addr_in;
      status_ff <= status_in;
      color_ff  <= color_in;
      index_ff  <= index_in;
      score_ff  <= score_in;
      if (start) begin
         want_r_ff <= req_red_in;
         want_g_ff <= req_green_in;
         want_b_ff <= req_blue_in;
      end
   end

   // pool memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_mem[mem_waddr] <= used_wdata;
         if (!used_wdata) begin
            pool_mem[mem_waddr] <= {req_red_in, req_green_in, req_blue_in};
         end
      end
      rd_color_ff <= pool_mem[addr_ff[AW-1:0]];
      rd_used_ff  <= used_mem[addr_ff[AW-1:0]];
      rd_idx_ff   <= addr_ff[AW-1:0];
   end

   assign chain_in = '{vld:   rd_vld_ff,
                       used:  rd_used_ff,
                       red:   rd_color_ff[23:16],
                       green: rd_color_ff[15:8],
                       blue:  rd_color_ff[7:0]};

   rcuc_score #(.IW(AW)) u_score (
      .clock      (clock),
      .reset      (reset),
      .want_red   (want_r_ff),
      .want_green (want_g_ff),
      .want_blue  (want_b_ff),
      .cand_i     (chain_in),
      .idx_i      (rd_idx_ff),
      .cand_o     (chain_out),
      .idx_o      (chain_idx),
      .score_o    (chain_score),
      .busy       (chain_busy)
   );

   rcuc_best #(.IW(AW)) u_best (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cand_i     (chain_out),
      .idx_i      (chain_idx),
      .score_i    (chain_score),
      .found      (found),
      .best_cand  (best_cand),
      .best_idx   (best_idx),
      .best_score (best_score)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_red   = found ? color_ff[23:16] : color_ff[23:16];
   assign rsp_match_green = color_ff[15:8];
   assign rsp_match_blue  = color_ff[7:0];
   assign rsp_match_index = index_ff;
   assign rsp_match_score = score_ff;

endmodule

// ----- hdl/rcuc_checker.sv -----
// Port-level checker for the redmean closest unused color block, with its bind.
`timescale 1ns / 1ps
`include "redmean_closest_unused_color_macros.svh"
module rcuc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_match_red,
   input logic [7:0]  rsp_match_green,
   input logic [7:0]  rsp_match_blue,
   input logic [11:0] rsp_match_index,
   input logic [19:0] rsp_match_score
);
   import rcuc_pkg::*;

   `RCUC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RCUC_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status <= STAT_CLEAR)
   `RCUC_ASSERT_NOW(a_nomatch_zero, clock, reset, rsp_valid && (rsp_status != STAT_MATCH),
      (rsp_match_red == 8'd0) && (rsp_match_green == 8'd0) && (rsp_match_blue == 8'd0) &&
      (rsp_match_index == 12'd0) && (rsp_match_score == 20'd0))
   `RCUC_ASSERT_NEXT(a_load_reply, clock, reset,
      req_valid && req_ready && (req_action == ACT_LOAD),
      rsp_valid && ((rsp_status == STAT_LOADED) || (rsp_status == STAT_FULL)))

endmodule

bind redmean_closest_unused_color rcuc_checker u_rcuc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_match_red   (rsp_match_red),
   .rsp_match_green (rsp_match_green),
   .rsp_match_blue  (rsp_match_blue),
   .rsp_match_index (rsp_match_index),
   .rsp_match_score (rsp_match_score)
);

// ----- test/redmean_closest_unused_color_tb.sv -----
// Testbench for the redmean closest unused color block: directed and random transfers.
`timescale 1ns / 1ps
module redmean_closest_unused_color_tb;
   import rcuc_pkg::*;

   localparam int POOL = 4096;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [2:0]  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] index;
      logic [19:0] score;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_LOAD;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_match_red;
   logic [7:0]  rsp_match_green;
   logic [7:0]  rsp_match_blue;
   logic [11:0] rsp_match_index;
   logic [19:0] rsp_match_score;

   // Shadow copy of the pool.
   logic [23:0] pool_rgb [POOL];
   logic        pool_taken [POOL];
   int          loaded_cnt;
   int          free_cnt;

   result_type  expected_q [$];
   int          error_cnt;
   int          cycle_cnt;
   bit          send_gaps;   // random sender idling on/off
   bit          recv_gaps;   // random receiver stalls on/off
   int          hold_cycles; // long receiver hold-off, counted down

   redmean_closest_unused_color DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [19:0] redmean_dist(logic [7:0] r1, logic [7:0] g1,
                                                logic [7:0] b1, logic [23:0] c);
      int mean, dr, dg, db;
      mean = (int'(r1) + int'(c[23:16])) / 2;
      dr = int'(r1) - int'(c[23:16]);
      dg = int'(g1) - int'(c[15:8]);
      db = int'(b1) - int'(c[7:0]);
      return 20'(((512 + mean) * dr * dr >>> 8) + 4 * dg * dg
                 + ((767 - mean) * db * db >>> 8));
   endfunction

   // Updates the shadow pool and queues the result a transfer should produce.
   task automatic predict_result(logic [1:0] act, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b);
      result_type res;
      int best;
      logic [19:0] best_score, s;
      res = '{STAT_LOADED, 0, 0, 0, 0, 0};
      best = -1;
      best_score = '0;
      case (act)
         ACT_LOAD: begin
            if (loaded_cnt >= POOL) begin
               res.status = STAT_FULL;
            end else begin
               pool_rgb[loaded_cnt] = {r, g, b};
               pool_taken[loaded_cnt] = 1'b0;
               loaded_cnt++;
               free_cnt++;
            end
         end
         ACT_CLEAR: begin
            loaded_cnt = 0;
            free_cnt = 0;
            res.status = STAT_CLEAR;
         end
         ACT_QUERY: begin
            if (free_cnt != 0) begin
               for (int i = 0; i < loaded_cnt; i++) begin
                  if (!pool_taken[i]) begin
                     s = redmean_dist(r, g, b, pool_rgb[i]);
                     if (best < 0 || s < best_score) begin
                        best = i;
                        best_score = s;
                     end
                  end
               end
            end
            if (best < 0) begin
               res.status = STAT_EMPTY;
            end else begin
               pool_taken[best] = 1'b1;
               free_cnt--;
               res = '{STAT_MATCH, pool_rgb[best][23:16], pool_rgb[best][15:8],
                       pool_rgb[best][7:0], 12'(best), best_score};
            end
         end
         default: return;  // undefined action: no result
      endcase
      expected_q = {expected_q, res};
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_cnt++;
   endtask

   // Drives one transfer; prediction happens at the accepting edge.
   // Valid stays up after the transfer until the next call or wait_idle drops it.
   task automatic send_item(logic [1:0] act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      do @(posedge clock); while (!req_ready);
      predict_result(act, r, g, b);
      @(negedge clock);
   endtask

   task automatic send_random(int load_weight);
      int k;
      k = $urandom_range(0, 99);
      if (k < load_weight)
         send_item(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (k < 95)
         send_item(ACT_QUERY, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (k < 98)
         send_item(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      else
         send_item(2'd3, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Waits until every queued result has arrived, then lets the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Receiver: random stall bursts, plus an optional long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transfer status", rsp_status, -1);
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_match_red !== want.red)
               report_mismatch("match_red", rsp_match_red, want.red);
            if (rsp_match_green !== want.green)
               report_mismatch("match_green", rsp_match_green, want.green);
            if (rsp_match_blue !== want.blue)
               report_mismatch("match_blue", rsp_match_blue, want.blue);
            if (rsp_match_index !== want.index)
               report_mismatch("match_index", rsp_match_index, want.index);
            if (rsp_match_score !== want.score)
               report_mismatch("match_score", rsp_match_score, want.score);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Empty-pool query, extremes, ties, undefined action, clear.
   task automatic test_directed();
      send_item(ACT_QUERY, 8'd10, 8'd20, 8'd30);
      send_item(ACT_LOAD, 8'd0, 8'd0, 8'd0);
      send_item(ACT_LOAD, 8'd255, 8'd255, 8'd255);
      send_item(ACT_LOAD, 8'd0, 8'd0, 8'd0);        // tie with slot 0
      send_item(ACT_LOAD, 8'd255, 8'd0, 8'd255);
      send_item(ACT_LOAD, 8'd0, 8'd255, 8'd0);
      send_item(2'd3, 8'd255, 8'd255, 8'd255);      // ignored
      send_item(ACT_QUERY, 8'd255, 8'd255, 8'd255);
      send_item(ACT_QUERY, 8'd255, 8'd255, 8'd255); // next best after the exact match
      send_item(ACT_QUERY, 8'd0, 8'd0, 8'd0);       // earliest of a tie
      send_item(ACT_QUERY, 8'd0, 8'd0, 8'd0);
      send_item(ACT_QUERY, 8'd0, 8'd0, 8'd0);
      send_item(ACT_QUERY, 8'd0, 8'd0, 8'd0);
      send_item(ACT_QUERY, 8'd0, 8'd0, 8'd0);       // all used
      send_item(ACT_CLEAR, 8'd0, 8'd0, 8'd0);
      send_item(ACT_QUERY, 8'd255, 8'd0, 8'd0);     // empty after clear
      send_item(ACT_LOAD, 8'haa, 8'h55, 8'hff);
      send_item(ACT_QUERY, 8'h55, 8'haa, 8'h00);
      wait_idle();
   endtask

   // Receiver holds off while the sender keeps offering; the block must stall.
   task automatic test_backpressure();
      @(posedge clock);
      hold_cycles = 400;
      @(negedge clock);
      repeat (12) send_item(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      repeat (4) send_item(ACT_QUERY, 8'($urandom), 8'($urandom), 8'($urandom));
      wait_idle();
   endtask

   // Random mix of loads and queries with random content; small pools keep scans short.
   task automatic test_random();
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      repeat (75) send_random(45);
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      repeat (31) send_random(45);
      wait_idle();
   endtask

   initial begin
      loaded_cnt = 0;
      free_cnt = 0;
      error_cnt = 0;
      cycle_cnt = 0;
      hold_cycles = 0;
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      if (error_cnt == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
